FILE: sv/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared constants and codes for the weighted random selector.
// ----------------------------------------------------------------------------
`default_nettype none

package wrs_pkg;

    // Default table depth and weight width
    localparam int MAX_ITEMS_DEF   = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    // Park-Miller generator constants
    localparam logic [14:0] PM_MULT = 15'd16807;
    localparam logic [30:0] PM_MOD  = 31'h7FFF_FFFF;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_SET_SLT = 2'd1,
        FUNC_SET_VAL = 2'd2,
        FUNC_DRAW    = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NONE     = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_SLOT = 2'd3
    } status_t;

endpackage

`default_nettype wire

FILE: sv/wrs_ram.sv
// ----------------------------------------------------------------------------
// wrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/wrs_mul.sv
// ----------------------------------------------------------------------------
// wrs_mul
// Serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wrs_mul #(
    parameter int AW = 31,
    parameter int BW = 21
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [AW-1:0]    a,
    input  wire logic [BW-1:0]    b,
    output logic                  done,
    output logic      [AW+BW-1:0] product
);

    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [PW-1:0] prod_reg, prod_next;
    logic [PW-1:0] mcand_reg, mcand_next;
    logic [BW-1:0] mplier_reg, mplier_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    // Add the shifted multiplicand for each set multiplier bit
    always_comb begin
        prod_next   = prod_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start) begin
            prod_next   = '0;
            mcand_next  = PW'(a);
            mplier_next = b;
            cnt_next    = CW'(BW);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                prod_next = prod_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

FILE: sv/weighted_random_selector.sv
// ----------------------------------------------------------------------------
// weighted_random_selector
// Weighted item table with a Park-Miller draw, run by a small sequencer.
// ----------------------------------------------------------------------------
// One request at a time; s_tready is high only while the sequencer is idle.
// Add and set-by-slot go from idle straight to the result push. Set-by-value
// reads the entries in order until a value matches. A draw sums all weights,
// steps the seed and starts the serial seed*sum multiply; SUMW = WEIGHT_BITS +
// clog2(MAX_ITEMS+1) is the width of that multiply, which
// holds the sequencer until it is done. The
// single read port of the weight memory, walked once per entry pair to
// form each item's cumulative threshold, is what bounds a draw. The result sits
// in an output register, so a pending result does not block the next request
// from being taken.
`default_nettype none

module weighted_random_selector #(
    parameter int MAX_ITEMS   = wrs_pkg::MAX_ITEMS_DEF,
    parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: seed_start
    input  wire logic        cfg_wr_en,
    input  wire logic [30:0] cfg_wr_data,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // slot[3:0], value_in[35:4], weight_in[51:36]
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // slot_out[3:0], value_out[35:4]
    output logic      [1:0]  m_tuser    // status[1:0]
);

    localparam int IDXW = $clog2(MAX_ITEMS);
    localparam int CNTW = $clog2(MAX_ITEMS + 1);
    localparam int SUMW = WEIGHT_BITS + CNTW;
    localparam int PW   = 31 + SUMW;

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_PUSH    = 15'b000000000000010,
        S_F_RD    = 15'b000000000000100,
        S_F_CMP   = 15'b000000000001000,
        S_SUM_RD  = 15'b000000000010000,
        S_SUM_ACC = 15'b000000000100000,
        S_SEED    = 15'b000000001000000,
        S_MUL     = 15'b000000010000000,
        S_J_RD    = 15'b000000100000000,
        S_J_CHK   = 15'b000001000000000,
        S_I_RD    = 15'b000010000000000,
        S_I_ACC   = 15'b000100000000000,
        S_J_CMP   = 15'b001000000000000,
        S_V_RD    = 15'b010000000000000,
        S_V_GET   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    // Request fields
    logic [1:0]             in_func;
    logic [3:0]             in_slot;
    logic [31:0]            in_value;
    logic [WEIGHT_BITS-1:0] in_weight;
    logic                   req;

    assign in_func   = s_tuser;
    assign in_slot   = s_tdata[3:0];
    assign in_value  = s_tdata[35:4];
    assign in_weight = WEIGHT_BITS'(s_tdata[51:36]);
    assign req       = s_tvalid && s_tready;

    // Control and datapath registers
    logic [CNTW-1:0]        count_reg, count_next;
    logic [30:0]            seed_reg, seed_next;
    logic [IDXW-1:0]        i_reg, i_next;
    logic [IDXW-1:0]        j_reg, j_next;
    logic [IDXW-1:0]        best_reg, best_next;
    logic                   found_reg, found_next;
    logic [SUMW-1:0]        sum_reg, sum_next;
    logic [SUMW-1:0]        cum_reg, cum_next;
    logic [SUMW-1:0]        best_cum_reg, best_cum_next;
    logic [WEIGHT_BITS-1:0] wj_reg, wj_next;
    logic [31:0]            val_reg, val_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [1:0]             res_st_reg, res_st_next;
    logic [3:0]             res_slot_reg, res_slot_next;
    logic [31:0]            res_val_reg, res_val_next;
    logic                   m_valid_reg, m_valid_next;
    logic [39:0]            m_data_reg, m_data_next;
    logic [1:0]             m_user_reg, m_user_next;

    // Memories
    logic                   wt_we, val_we;
    logic [IDXW-1:0]        wt_waddr, wt_raddr, val_raddr;
    logic [WEIGHT_BITS-1:0] wt_wdata, wt_rdata;
    logic [31:0]            val_rdata;

    wrs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ITEMS)) u_wt_ram (
        .aclk  (aclk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (wt_wdata),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    wrs_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (count_reg[IDXW-1:0]),
        .wdata (in_value),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    // Serial seed*sum multiplier
    logic          mul_start, mul_done;
    logic [PW-1:0] mul_prod;

    wrs_mul #(.AW(31), .BW(SUMW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (seed_next),
        .b       (sum_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Generator step: seed*16807 folded mod 2^31-1
    logic [45:0] seed_prod;
    logic [31:0] seed_fold;
    logic [30:0] seed_step;

    always_comb begin
        seed_prod = seed_reg * wrs_pkg::PM_MULT;
        seed_fold = 32'(seed_prod[30:0]) + 32'(seed_prod[45:31]);
        if (seed_fold >= 32'(wrs_pkg::PM_MOD)) begin
            seed_step = 31'(seed_fold - 32'(wrs_pkg::PM_MOD));
        end else begin
            seed_step = seed_fold[30:0];
        end
    end

    // Threshold compare: seed*sum >= cum*(2^31-1)
    logic [PW-1:0] cum_scaled;
    logic          thr_ok;
    logic          last_i, last_j, i_before_j;
    logic [SUMW-1:0] sum_acc;

    assign cum_scaled = {cum_reg, 31'd0} - PW'(cum_reg);
    assign thr_ok     = mul_prod >= cum_scaled;
    assign last_i     = CNTW'(i_reg) == count_reg - 1'b1;
    assign last_j     = CNTW'(j_reg) == count_reg - 1'b1;
    assign i_before_j = (i_reg != j_reg) &&
                        ((wt_rdata < wj_reg) || (wt_rdata == wj_reg && i_reg < j_reg));
    assign sum_acc    = sum_reg + SUMW'(wt_rdata);

    // Read address select
    assign wt_raddr  = (state_reg == S_J_RD) ? j_reg : i_reg;
    assign val_raddr = (state_reg == S_V_RD) ? best_reg : i_reg;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        seed_next     = seed_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        sum_next      = sum_reg;
        cum_next      = cum_reg;
        best_cum_next = best_cum_reg;
        wj_next       = wj_reg;
        val_next      = val_reg;
        w_next        = w_reg;
        res_st_next   = res_st_reg;
        res_slot_next = res_slot_reg;
        res_val_next  = res_val_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        wt_we         = 1'b0;
        wt_waddr      = i_reg;
        wt_wdata      = w_reg;
        val_we        = 1'b0;
        mul_start     = 1'b0;

        // Drop the result once taken
        if (m_tvalid && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (req) begin
                    val_next      = in_value;
                    w_next        = in_weight;
                    res_st_next   = wrs_pkg::ST_OK;
                    res_slot_next = '0;
                    res_val_next  = '0;
                    i_next        = '0;
                    sum_next      = '0;
                    state_next    = S_PUSH;
                    unique case (in_func)
                        wrs_pkg::FUNC_ADD: begin
                            if (count_reg >= CNTW'(MAX_ITEMS)) begin
                                res_st_next = wrs_pkg::ST_FULL;
                            end else begin
                                wt_we         = 1'b1;
                                wt_waddr      = count_reg[IDXW-1:0];
                                wt_wdata      = in_weight;
                                val_we        = 1'b1;
                                res_slot_next = 4'(count_reg);
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        wrs_pkg::FUNC_SET_SLT: begin
                            if ({4'd0, in_slot} >= 8'(count_reg)) begin
                                res_st_next = wrs_pkg::ST_BAD_SLOT;
                            end else begin
                                wt_we    = 1'b1;
                                wt_waddr = IDXW'(in_slot);
                                wt_wdata = in_weight;
                            end
                        end
                        wrs_pkg::FUNC_SET_VAL: begin
                            if (count_reg == '0) begin
                                res_st_next = wrs_pkg::ST_NONE;
                            end else begin
                                state_next = S_F_RD;
                            end
                        end
                        default: begin
                            if (count_reg == '0) begin
                                res_st_next = wrs_pkg::ST_NONE;
                            end else begin
                                state_next = S_SUM_RD;
                            end
                        end
                    endcase
                end
            end
            S_F_RD: begin
                state_next = S_F_CMP;
            end
            S_F_CMP: begin
                if (val_rdata == val_reg) begin
                    wt_we      = 1'b1;
                    state_next = S_PUSH;
                end else if (last_i) begin
                    res_st_next = wrs_pkg::ST_NONE;
                    state_next  = S_PUSH;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_F_RD;
                end
            end
            S_SUM_RD: begin
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                sum_next = sum_acc;
                if (!last_i) begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SUM_RD;
                end else if (sum_acc == '0) begin
                    res_st_next = wrs_pkg::ST_NONE;
                    state_next  = S_PUSH;
                end else begin
                    state_next = S_SEED;
                end
            end
            S_SEED: begin
                seed_next  = seed_step;
                mul_start  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                if (mul_done) begin
                    j_next        = '0;
                    found_next    = 1'b0;
                    best_next     = '0;
                    best_cum_next = '0;
                    state_next    = S_J_RD;
                end
            end
            S_J_RD: begin
                state_next = S_J_CHK;
            end
            S_J_CHK: begin
                wj_next  = wt_rdata;
                i_next   = '0;
                cum_next = '0;
                if (wt_rdata != '0) begin
                    state_next = S_I_RD;
                end else if (last_j) begin
                    state_next = S_V_RD;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_J_RD;
                end
            end
            S_I_RD: begin
                state_next = S_I_ACC;
            end
            S_I_ACC: begin
                if (i_before_j) begin
                    cum_next = cum_reg + SUMW'(wt_rdata);
                end
                if (last_i) begin
                    state_next = S_J_CMP;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_I_RD;
                end
            end
            S_J_CMP: begin
                // Keep the positive item with the highest passing threshold
                if (thr_ok && (!found_reg || cum_reg > best_cum_reg)) begin
                    found_next    = 1'b1;
                    best_cum_next = cum_reg;
                    best_next     = j_reg;
                end
                if (last_j) begin
                    state_next = S_V_RD;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_J_RD;
                end
            end
            S_V_RD: begin
                state_next = S_V_GET;
            end
            S_V_GET: begin
                if (found_reg) begin
                    res_slot_next = 4'(best_reg);
                    res_val_next  = val_rdata;
                end else begin
                    res_st_next = wrs_pkg::ST_NONE;
                end
                state_next = S_PUSH;
            end
            S_PUSH: begin
                // Hold until the output register is free
                if (!m_tvalid || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, res_val_reg, res_slot_reg};
                    m_user_next  = res_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Seed load from configuration
        if (cfg_wr_en) begin
            seed_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            seed_reg    <= 31'd1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            seed_reg    <= seed_next;
            m_valid_reg <= m_valid_next;
        end
        i_reg        <= i_next;
        j_reg        <= j_next;
        best_reg     <= best_next;
        found_reg    <= found_next;
        sum_reg      <= sum_next;
        cum_reg      <= cum_next;
        best_cum_reg <= best_cum_next;
        wj_reg       <= wj_next;
        val_reg      <= val_next;
        w_reg        <= w_next;
        res_st_reg   <= res_st_next;
        res_slot_reg <= res_slot_next;
        res_val_reg  <= res_val_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(MAX_ITEMS))
        else $error("item count exceeds table depth");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        req |=> !s_tready)
        else $error("request taken while busy");

    a_mul_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == S_MUL)
        else $error("multiplier finished outside its wait state");

    a_j_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_J_CMP) |-> CNTW'(j_reg) < count_reg)
        else $error("draw index beyond item count");

endmodule

`default_nettype wire
